@@ rtl/core/pgp_pkg.sv @@
// package for the planar geometric predicates block
// holds the mode and result codes and the pipeline control struct; no dependencies
package pgp_pkg;

	typedef enum logic [1:0] {
		KIND_LINE   = 2'd0,
		KIND_TRI    = 2'd1,
		KIND_CIRCLE = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	// two's complement sign codes: +1, 0, -1
	typedef enum logic [1:0] {
		REL_ZERO = 2'b00,
		REL_POS  = 2'b01,
		REL_NEG  = 2'b11
	} rel_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} ctl_t;

endpackage

@@ rtl/core/pgp_if.sv @@
// valid/ready channel interfaces for the query and result sides
// standalone, no package needed
interface pgp_query_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] second_x;
	logic signed [COORD_BITS-1:0] second_y;
	logic signed [COORD_BITS-1:0] third_x;
	logic signed [COORD_BITS-1:0] third_y;

	modport source (
		output valid, kind, point_x, point_y, first_x, first_y,
		       second_x, second_y, third_x, third_y,
		input  ready
	);
	modport sink (
		input  valid, kind, point_x, point_y, first_x, first_y,
		       second_x, second_y, third_x, third_y,
		output ready
	);
endinterface

interface pgp_result_if;
	logic              valid;
	logic              ready;
	logic signed [1:0] relation;

	modport source (output valid, relation, input ready);
	modport sink (input valid, relation, output ready);
endinterface

@@ rtl/core/pgp_front.sv @@
// front half of the predicate pipeline: differences, products, minors and lifts
// depends on pgp_pkg
module pgp_front
	import pgp_pkg::*;
#(
	parameter int COORD_BITS = 16,
	localparam int W = 2*COORD_BITS + 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctl_t                         in_ctl,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	input  logic signed [COORD_BITS-1:0] vx [3],
	input  logic signed [COORD_BITS-1:0] vy [3],
	output ctl_t                         out_ctl,
	input  logic                         out_ready,
	output logic signed [W-1:0]          minor [3],
	output logic signed [W-1:0]          lift [3]
);

	localparam int D  = COORD_BITS + 1;
	localparam int PR = 2*COORD_BITS + 2;
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [D-1:0]  dx_s1 [3];
	logic signed [D-1:0]  dy_s1 [3];
	logic signed [D-1:0]  sx_s1 [3];
	logic signed [D-1:0]  sy_s1 [3];
	logic signed [PR-1:0] pa_s2 [3];
	logic signed [PR-1:0] pb_s2 [3];
	logic signed [PR-1:0] zx_s2 [3];
	logic signed [PR-1:0] zy_s2 [3];
	logic signed [W-1:0]  minor_s3 [3];
	logic signed [W-1:0]  lift_s3 [3];

	// a stage takes a new beat when it is empty or its contents move on
	assign rdy_s3   = !ctl_s3.valid || out_ready;
	assign rdy_s2   = !ctl_s2.valid || rdy_s3;
	assign rdy_s1   = !ctl_s1.valid || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (rdy_s1) ctl_s1 <= in_ctl;
			if (rdy_s2) ctl_s2 <= ctl_s1;
			if (rdy_s3) ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (rdy_s1) begin
				dx_s1[k] <= D'(vx[k]) - D'(px);
				dy_s1[k] <= D'(vy[k]) - D'(py);
				sx_s1[k] <= D'(vx[k]) + D'(px);
				sy_s1[k] <= D'(vy[k]) + D'(py);
			end
			// minor k pairs the other two vertices; lift is |v|^2 - |p|^2
			if (rdy_s2) begin
				pa_s2[k] <= PR'(dx_s1[NXT[k]]) * PR'(dy_s1[PRV[k]]);
				pb_s2[k] <= PR'(dx_s1[PRV[k]]) * PR'(dy_s1[NXT[k]]);
				zx_s2[k] <= PR'(sx_s1[k]) * PR'(dx_s1[k]);
				zy_s2[k] <= PR'(sy_s1[k]) * PR'(dy_s1[k]);
			end
			if (rdy_s3) begin
				minor_s3[k] <= W'(pa_s2[k]) - W'(pb_s2[k]);
				lift_s3[k]  <= W'(zx_s2[k]) + W'(zy_s2[k]);
			end
		end
	end

	assign out_ctl = ctl_s3;
	assign minor   = minor_s3;
	assign lift    = lift_s3;

endmodule

@@ rtl/core/pgp_det.sv @@
// back half of the predicate pipeline: split wide products, determinant sum, sign
// depends on pgp_pkg
module pgp_det
	import pgp_pkg::*;
#(
	parameter int COORD_BITS = 16,
	localparam int W = 2*COORD_BITS + 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                in_ctl,
	output logic                in_ready,
	input  logic signed [W-1:0] minor [3],
	input  logic signed [W-1:0] lift [3],
	output logic                out_valid,
	input  logic                out_ready,
	output rel_t                out_rel
);

	localparam int K   = COORD_BITS + 2;
	localparam int H   = W - K;
	localparam int PL  = 2*K;
	localparam int PX  = K + 1 + H;
	localparam int PHH = 2*H;
	localparam int T   = 4*COORD_BITS + 8;

	ctl_t ctl_s4, ctl_s5, ctl_s6;
	logic rdy_s4, rdy_s5, rdy_s6;
	rel_t pre_d, pre_s4, pre_s5, rel_s6, rel_d;

	logic [PL-1:0]         pll_s4 [3];
	logic signed [PX-1:0]  plh_s4 [3];
	logic signed [PX-1:0]  phl_s4 [3];
	logic signed [PHH-1:0] phh_s4 [3];
	logic signed [T-1:0]   term_s5 [3];
	logic signed [T-1:0]   total;
	logic [2:0]            neg, zero;

	assign rdy_s6   = !ctl_s6.valid || out_ready;
	assign rdy_s5   = !ctl_s5.valid || rdy_s6;
	assign rdy_s4   = !ctl_s4.valid || rdy_s5;
	assign in_ready = rdy_s4;

	// line and triangle answers come from the minor signs alone
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			neg[k]  = minor[k][W-1];
			zero[k] = (minor[k] == '0);
		end
		case (in_ctl.kind)
			KIND_LINE:   pre_d = neg[2] ? REL_POS : (zero[2] ? REL_ZERO : REL_NEG);
			KIND_TRI:    pre_d = (|neg) ? REL_POS : ((|zero) ? REL_ZERO : REL_NEG);
			default:     pre_d = REL_ZERO;
		endcase
	end

	assign total = term_s5[0] + term_s5[1] + term_s5[2];

	always_comb begin
		case (ctl_s5.kind) inside
			KIND_LINE, KIND_TRI: rel_d = pre_s5;
			KIND_CIRCLE: begin
				if (total[T-1])
					rel_d = REL_POS;
				else if (total == '0)
					rel_d = REL_ZERO;
				else
					rel_d = REL_NEG;
			end
			default: rel_d = REL_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			if (rdy_s4) ctl_s4 <= in_ctl;
			if (rdy_s5) ctl_s5 <= ctl_s4;
			if (rdy_s6) ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) pre_s4 <= pre_d;
		if (rdy_s5) pre_s5 <= pre_s4;
		if (rdy_s6) rel_s6 <= rel_d;
		for (int k = 0; k < 3; k++) begin
			// lift * minor as four half-width partial products
			if (rdy_s4) begin
				pll_s4[k] <= PL'(lift[k][K-1:0]) * PL'(minor[k][K-1:0]);
				plh_s4[k] <= PX'($signed({1'b0, lift[k][K-1:0]})) *
				             PX'($signed(minor[k][W-1:K]));
				phl_s4[k] <= PX'($signed(lift[k][W-1:K])) *
				             PX'($signed({1'b0, minor[k][K-1:0]}));
				phh_s4[k] <= PHH'($signed(lift[k][W-1:K])) *
				             PHH'($signed(minor[k][W-1:K]));
			end
			if (rdy_s5) begin
				term_s5[k] <= (T'(phh_s4[k]) <<< (2*K)) +
				              ((T'(plh_s4[k]) + T'(phl_s4[k])) <<< K) +
				              T'(pll_s4[k]);
			end
		end
	end

	assign out_valid = ctl_s6.valid;
	assign out_rel   = rel_s6;

`ifndef SYNTHESIS
	a_line_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		in_ctl.valid && rdy_s4 && in_ctl.kind == KIND_LINE && minor[2] == '0
		|=> pre_s4 == REL_ZERO)
		else $error("line test on the line did not give zero");

	a_circle_on_rim: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s5.valid && rdy_s6 && ctl_s5.kind == KIND_CIRCLE && total == '0
		|=> rel_s6 == REL_ZERO)
		else $error("zero determinant did not give zero");

	a_unused_kind: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s6.valid && ctl_s6.kind == KIND_UNUSED |-> rel_s6 == REL_ZERO)
		else $error("unused mode gave a nonzero relation");
`endif

endmodule

@@ rtl/core/planar_geometric_predicates.sv @@
// top level of the 2d orientation / incircle predicate pipeline
// depends on pgp_pkg, pgp_if, pgp_front and pgp_det
//
//   channel  | dir | handshake    | payload
//   query    | in  | valid/ready  | kind, point_x/y, first_x/y, second_x/y, third_x/y
//   result   | out | valid/ready  | relation
//
// one beat per cycle sustained while the result side is ready.
// stages: differences, products, minors and lifts, partial products of the
// lifted determinant, per-term sums, final sum with sign (result register).
// arst_n clears the stage valid bits only; no warm-up after reset.
// each stage holds while the next is full and stalled, so bubbles close up under a stall
module planar_geometric_predicates
	import pgp_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	pgp_query_if.sink   query,
	pgp_result_if.source result
);

	localparam int W = 2*COORD_BITS + 3;

	ctl_t                         front_in, front_out;
	logic                         det_ready, det_valid;
	rel_t                         det_rel;
	logic signed [COORD_BITS-1:0] vx [3];
	logic signed [COORD_BITS-1:0] vy [3];
	logic signed [W-1:0]          minor [3];
	logic signed [W-1:0]          lift [3];

	assign front_in.valid = query.valid;
	assign front_in.kind  = kind_t'(query.kind);

	assign vx[0] = query.first_x;
	assign vy[0] = query.first_y;
	assign vx[1] = query.second_x;
	assign vy[1] = query.second_y;
	assign vx[2] = query.third_x;
	assign vy[2] = query.third_y;

	pgp_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (front_in),
		.in_ready  (query.ready),
		.px        (query.point_x),
		.py        (query.point_y),
		.vx        (vx),
		.vy        (vy),
		.out_ctl   (front_out),
		.out_ready (det_ready),
		.minor     (minor),
		.lift      (lift)
	);

	pgp_det #(.COORD_BITS(COORD_BITS)) u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (front_out),
		.in_ready  (det_ready),
		.minor     (minor),
		.lift      (lift),
		.out_valid (det_valid),
		.out_ready (result.ready),
		.out_rel   (det_rel)
	);

	assign result.valid    = det_valid;
	assign result.relation = $signed(det_rel);

`ifndef SYNTHESIS
	// input back-pressure only once every stage holds a beat
	a_full_before_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!query.ready |-> result.valid)
		else $error("query stalled with a free stage");

	a_rel_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.relation != 2'b10)
		else $error("relation code out of range");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !result.valid)
		else $error("result valid right after reset");
`endif

endmodule

@@ sim/tb_planar_geometric_predicates.sv @@
`timescale 1ns / 100ps
// self-checking testbench for planar_geometric_predicates: line, triangle, circumcircle and unused-mode tests
// depends on pgp_pkg, pgp_if and the rtl under rtl/core
module tb_planar_geometric_predicates;
	import pgp_pkg::*;

	localparam int COORD_BITS     = 16;
	localparam int RANDOM_QUERIES = 800;
	localparam int DRAIN_CYCLES   = 24;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int BACKLOG_CYCLES = 150;

	typedef struct {
		kind_t                        kind;
		logic signed [COORD_BITS-1:0] point_x, point_y;
		logic signed [COORD_BITS-1:0] first_x, first_y;
		logic signed [COORD_BITS-1:0] second_x, second_y;
		logic signed [COORD_BITS-1:0] third_x, third_y;
	} query_item_t;

	logic clk;
	logic arst_n;

	pgp_query_if #(.COORD_BITS(COORD_BITS)) query_bus ();
	pgp_result_if result_bus ();

	planar_geometric_predicates #(
		.COORD_BITS(COORD_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query_bus),
		.result(result_bus)
	);

	query_item_t pending_queries[$];
	rel_t        expected_relations[$];

	int queries_offered = 0;
	int queries_taken   = 0;
	int results_taken   = 0;
	int results_counted = 0;
	int fail_count      = 0;
	int cycle_count     = 0;
	int gap_left        = 0;
	int stall_left      = 0;
	int backlog_hold    = 0;
	logic calm_tx       = 1'b0;
	logic calm_rx       = 1'b0;

	// integer points on a circle of radius 5 around the origin
	int ring_x[12] = '{5, 0, -5, 0, 3, 4, -3, -4, 3, 4, -3, -4};
	int ring_y[12] = '{0, 5, 0, -5, 4, 3, 4, 3, -4, -3, -4, -3};

	function automatic rel_t sign_code(longint v);
		if (v > 0)
			return REL_POS;
		if (v < 0)
			return REL_NEG;
		return REL_ZERO;
	endfunction

	function automatic rel_t orientation(longint px, longint py, longint ax, longint ay,
	                                     longint bx, longint by);
		return sign_code((px - ax) * (by - ay) - (bx - ax) * (py - ay));
	endfunction

	function automatic rel_t triangle_relation(query_item_t q);
		rel_t s0, s1, s2;
		s0 = orientation(q.point_x, q.point_y, q.second_x, q.second_y, q.third_x, q.third_y);
		if (s0 == REL_POS)
			return REL_POS;
		s1 = orientation(q.point_x, q.point_y, q.first_x, q.first_y, q.third_x, q.third_y);
		if (s1 == REL_NEG)
			return REL_POS;
		s2 = orientation(q.point_x, q.point_y, q.first_x, q.first_y, q.second_x, q.second_y);
		if (s2 == REL_POS)
			return REL_POS;
		if (s0 == REL_ZERO || s1 == REL_ZERO || s2 == REL_ZERO)
			return REL_ZERO;
		return REL_NEG;
	endfunction

	function automatic rel_t circle_relation(query_item_t q);
		longint px, py;
		longint vx[3], vy[3], dx[3], dy[3], lift[3], minor[3];
		logic signed [127:0] det, wide_lift, wide_minor;
		int k;
		px = q.point_x;
		py = q.point_y;
		vx[0] = q.first_x;  vy[0] = q.first_y;
		vx[1] = q.second_x; vy[1] = q.second_y;
		vx[2] = q.third_x;  vy[2] = q.third_y;
		for (k = 0; k < 3; k++) begin
			dx[k] = vx[k] - px;
			dy[k] = vy[k] - py;
			// |v|^2 - |p|^2 without leaving 64 bits
			lift[k] = (vx[k] + px) * dx[k] + (vy[k] + py) * dy[k];
		end
		minor[0] = dx[1] * dy[2] - dx[2] * dy[1];
		minor[1] = dx[2] * dy[0] - dx[0] * dy[2];
		minor[2] = dx[0] * dy[1] - dx[1] * dy[0];
		det = '0;
		for (k = 0; k < 3; k++) begin
			wide_lift  = lift[k];
			wide_minor = minor[k];
			det += wide_lift * wide_minor;
		end
		if (det < 0)
			return REL_POS;
		if (det == 0)
			return REL_ZERO;
		return REL_NEG;
	endfunction

	function automatic rel_t predict_relation(query_item_t q);
		case (q.kind)
			KIND_LINE:
				return orientation(q.point_x, q.point_y, q.first_x, q.first_y,
				                   q.second_x, q.second_y);
			KIND_TRI:    return triangle_relation(q);
			KIND_CIRCLE: return circle_relation(q);
			default:     return REL_ZERO;
		endcase
	endfunction

	function automatic query_item_t make_query(kind_t kind, int px, int py, int x0, int y0,
	                                           int x1, int y1, int x2, int y2);
		query_item_t q;
		q.kind     = kind;
		q.point_x  = px; q.point_y  = py;
		q.first_x  = x0; q.first_y  = y0;
		q.second_x = x1; q.second_y = y1;
		q.third_x  = x2; q.third_y  = y2;
		return q;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d query beats taken, %0d results outstanding",
			         $time, queries_taken, queries_offered, expected_relations.size());
			$display("tb_planar_geometric_predicates NOT OK");
			$finish;
		end
	end

	// sender: one beat per queued item, random gap after each accepted beat
	always @(negedge clk) begin : feed_queries
		query_item_t nxt;
		logic offer;
		if (arst_n) begin
			offer = 1'b0;
			if (query_bus.valid) begin
				if (queries_taken == queries_offered) begin
					gap_left = calm_tx ? 0 : $urandom_range(0, 13);
					if ($urandom_range(0, 39) == 0)
						calm_tx = !calm_tx;
					offer = (gap_left == 0) && (pending_queries.size() != 0);
					if (!offer)
						query_bus.valid <= 1'b0;
				end
			end else if (gap_left != 0) begin
				gap_left--;
			end else begin
				offer = pending_queries.size() != 0;
			end
			if (offer) begin
				nxt = pending_queries.pop_front();
				query_bus.kind     <= nxt.kind;
				query_bus.point_x  <= nxt.point_x;
				query_bus.point_y  <= nxt.point_y;
				query_bus.first_x  <= nxt.first_x;
				query_bus.first_y  <= nxt.first_y;
				query_bus.second_x <= nxt.second_x;
				query_bus.second_y <= nxt.second_y;
				query_bus.third_x  <= nxt.third_x;
				query_bus.third_y  <= nxt.third_y;
				query_bus.valid    <= 1'b1;
				queries_offered    <= queries_offered + 1;
			end
		end
	end

	// receiver: random stall per result, plus two long holds to back up the pipe
	always @(negedge clk) begin : drain_results
		if (arst_n) begin
			if (results_taken != results_counted) begin
				results_counted = results_taken;
				stall_left = calm_rx ? 0 : $urandom_range(0, 13);
				if (results_taken == 150 || results_taken == 600)
					backlog_hold = BACKLOG_CYCLES;
				if ($urandom_range(0, 39) == 0)
					calm_rx = !calm_rx;
			end
			if (backlog_hold != 0) begin
				backlog_hold--;
				result_bus.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		query_item_t seen;
		rel_t want;
		if (arst_n) begin
			if (query_bus.valid && query_bus.ready) begin
				seen = make_query(kind_t'(query_bus.kind), query_bus.point_x, query_bus.point_y,
				                  query_bus.first_x, query_bus.first_y,
				                  query_bus.second_x, query_bus.second_y,
				                  query_bus.third_x, query_bus.third_y);
				expected_relations.push_back(predict_relation(seen));
				queries_taken <= queries_taken + 1;
			end
			if (result_bus.valid && result_bus.ready) begin
				results_taken <= results_taken + 1;
				if (expected_relations.size() == 0) begin
					fail_count++;
					$display("%0t: relation beat %0d with nothing expected, got %0d",
					         $time, results_taken, result_bus.relation);
				end else begin
					want = expected_relations.pop_front();
					if (result_bus.relation !== want) begin
						fail_count++;
						$display("%0t: relation mismatch on beat %0d: expected %0d, got %0d",
						         $time, results_taken, $signed(want), result_bus.relation);
					end
				end
			end
		end
	end

	initial begin : stimulus
		query_item_t item;
		int coord[8];
		int ax, ay, wx, wy, steps, j, cx, cy, reach, scale, shape, pick, idx, total;
		arst_n = 1'b0;
		query_bus.valid    = 1'b0;
		query_bus.kind     = KIND_LINE;
		query_bus.point_x  = '0; query_bus.point_y  = '0;
		query_bus.first_x  = '0; query_bus.first_y  = '0;
		query_bus.second_x = '0; query_bus.second_y = '0;
		query_bus.third_x  = '0; query_bus.third_y  = '0;
		result_bus.ready   = 1'b0;

		// directed: extremes, each mode, boundaries and degenerate vertices
		pending_queries.push_back(make_query(KIND_LINE, 0, 0, -32768, -32768, 32767, 32767, 0, 0));
		pending_queries.push_back(make_query(KIND_LINE, 32767, -32768, -32768, -32768,
		                                     32767, 32767, 5, 5));
		pending_queries.push_back(make_query(KIND_LINE, -32768, 32767, -32768, -32768,
		                                     32767, 32767, -1, -1));
		pending_queries.push_back(make_query(KIND_LINE, 7, 9, 3, 3, 3, 3, 0, 0));
		pending_queries.push_back(make_query(KIND_TRI, 0, 0, -100, -100, 100, -100, 0, 100));
		pending_queries.push_back(make_query(KIND_TRI, 0, 0, -100, -100, 0, 100, 100, -100));
		pending_queries.push_back(make_query(KIND_TRI, 0, -100, -100, -100, 100, -100, 0, 100));
		pending_queries.push_back(make_query(KIND_TRI, 100, -100, -100, -100, 100, -100, 0, 100));
		pending_queries.push_back(make_query(KIND_TRI, 32767, 32767, -100, -100, 100, -100,
		                                     0, 100));
		pending_queries.push_back(make_query(KIND_TRI, 0, 0, -32768, -32768, 32767, -32768,
		                                     0, 32767));
		pending_queries.push_back(make_query(KIND_TRI, -32768, 32767, -32768, -32768,
		                                     32767, -32768, 0, 32767));
		pending_queries.push_back(make_query(KIND_TRI, 5, 5, 0, 0, 10, 10, 20, 20));
		pending_queries.push_back(make_query(KIND_TRI, 5, 6, 0, 0, 10, 10, 20, 20));
		pending_queries.push_back(make_query(KIND_TRI, 4, 4, 4, 4, 4, 4, 4, 4));
		pending_queries.push_back(make_query(KIND_CIRCLE, 0, 0, 5, 0, 0, 5, -5, 0));
		pending_queries.push_back(make_query(KIND_CIRCLE, 3, 4, 5, 0, 0, 5, -5, 0));
		pending_queries.push_back(make_query(KIND_CIRCLE, 0, -6, 5, 0, 0, 5, -5, 0));
		pending_queries.push_back(make_query(KIND_CIRCLE, 0, 0, -5, 0, 0, 5, 5, 0));
		// rectangle corners at full scale are cocircular
		pending_queries.push_back(make_query(KIND_CIRCLE, -32768, 32767, -32768, -32768,
		                                     32767, -32768, 32767, 32767));
		pending_queries.push_back(make_query(KIND_CIRCLE, 0, 0, -32768, -32768,
		                                     32767, -32768, 32767, 32767));
		pending_queries.push_back(make_query(KIND_CIRCLE, 32767, -32768, -32768, 32767,
		                                     -32768, -32768, 32767, 32767));
		pending_queries.push_back(make_query(KIND_CIRCLE, 5, 0, 0, 0, 1, 1, 2, 2));
		pending_queries.push_back(make_query(KIND_CIRCLE, 1, 2, 9, 9, 9, 9, 9, 9));
		pending_queries.push_back(make_query(KIND_UNUSED, -32768, 32767, -32768, 32767,
		                                     -32768, 32767, -32768, 32767));
		pending_queries.push_back(make_query(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));

		for (int n = 0; n < RANDOM_QUERIES; n++) begin
			shape = $urandom_range(0, 9);
			if ($urandom_range(0, 15) == 0)
				item.kind = KIND_UNUSED;
			else
				item.kind = kind_t'($urandom_range(0, 2));
			case (shape)
				0, 1, 2: begin
					for (int c = 0; c < 8; c++)
						coord[c] = $urandom_range(0, 65535) - 32768;
				end
				3, 4: begin
					// tiny grid, lots of collinear and coincident cases
					for (int c = 0; c < 8; c++)
						coord[c] = $urandom_range(0, 16) - 8;
				end
				5: begin
					// query point on a lattice edge or at one of its ends
					ax = $urandom_range(0, 2000) - 1000;
					ay = $urandom_range(0, 2000) - 1000;
					wx = $urandom_range(0, 100) - 50;
					wy = $urandom_range(0, 100) - 50;
					steps = $urandom_range(1, 20);
					j = $urandom_range(0, steps);
					coord[0] = ax + j * wx;
					coord[1] = ay + j * wy;
					cx = $urandom_range(0, 4000) - 2000;
					cy = $urandom_range(0, 4000) - 2000;
					case ($urandom_range(0, 2))
						0: begin
							coord[2] = ax;                coord[3] = ay;
							coord[4] = ax + steps * wx;   coord[5] = ay + steps * wy;
							coord[6] = cx;                coord[7] = cy;
						end
						1: begin
							coord[2] = cx;                coord[3] = cy;
							coord[4] = ax;                coord[5] = ay;
							coord[6] = ax + steps * wx;   coord[7] = ay + steps * wy;
						end
						default: begin
							coord[2] = ax;                coord[3] = ay;
							coord[4] = cx;                coord[5] = cy;
							coord[6] = ax + steps * wx;   coord[7] = ay + steps * wy;
						end
					endcase
					item.kind = kind_t'($urandom_range(0, 1));
				end
				6, 7: begin
					// scaled integer circle: point on it, at its center or nearby
					cx = $urandom_range(0, 40000) - 20000;
					cy = $urandom_range(0, 40000) - 20000;
					reach = 32767 - ((cx < 0 ? -cx : cx) > (cy < 0 ? -cy : cy) ?
					                 (cx < 0 ? -cx : cx) : (cy < 0 ? -cy : cy));
					scale = 1 + $urandom_range(0, reach / 5 - 1);
					for (int c = 1; c < 4; c++) begin
						idx = $urandom_range(0, 11);
						coord[2*c]   = cx + scale * ring_x[idx];
						coord[2*c+1] = cy + scale * ring_y[idx];
					end
					pick = $urandom_range(0, 2);
					idx = $urandom_range(0, 11);
					if (pick == 0) begin
						coord[0] = cx + scale * ring_x[idx];
						coord[1] = cy + scale * ring_y[idx];
					end else if (pick == 1) begin
						coord[0] = cx;
						coord[1] = cy;
					end else begin
						coord[0] = cx + $urandom_range(0, 10 * scale) - 5 * scale;
						coord[1] = cy + $urandom_range(0, 10 * scale) - 5 * scale;
					end
					if (item.kind != KIND_UNUSED)
						item.kind = KIND_CIRCLE;
				end
				8: begin
					for (int c = 0; c < 8; c++)
						coord[c] = $urandom_range(0, 2000) - 1000;
				end
				default: begin
					for (int c = 0; c < 8; c++) begin
						case ($urandom_range(0, 4))
							0: coord[c] = -32768;
							1: coord[c] = 32767;
							2: coord[c] = 0;
							3: coord[c] = -1;
							default: coord[c] = $urandom_range(0, 65535) - 32768;
						endcase
					end
				end
			endcase
			pending_queries.push_back(make_query(item.kind, coord[0], coord[1], coord[2],
			                                     coord[3], coord[4], coord[5], coord[6],
			                                     coord[7]));
		end
		total = pending_queries.size();

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		while (queries_taken != total || expected_relations.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("tb_planar_geometric_predicates OK");
		else
			$display("tb_planar_geometric_predicates NOT OK");
		$finish;
	end

endmodule
